/* hw/rtl/lts_pkg.sv */
package lts_pkg;

    localparam int POSITION_BITS = 24;
    localparam int CORDIC_STEPS  = 16;
    localparam int NSTEPS        = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int CNT_W         = $clog2(NSTEPS);
    localparam int DW            = POSITION_BITS + 1;
    localparam int CW            = POSITION_BITS + 4;
    localparam int ZW            = 24;
    localparam int BW            = 18;
    localparam int PW            = CW + BW;

    localparam logic signed [ZW-1:0] ANG_PI_HALF = 24'sd1647099;
    localparam logic signed [16:0]   Q13_PI      = 17'sd25736;
    localparam logic signed [16:0]   Q13_TWO_PI  = 17'sd51472;
    localparam logic signed [PW-1:0] RATE_MAX    = PW'(12868);
    localparam logic signed [BW-1:0] INV_GAIN    = 18'sd39797;

    localparam logic [2:0] REG_HEADING_GAIN    = 3'd0;
    localparam logic [2:0] REG_OFFSET_GAIN     = 3'd1;
    localparam logic [2:0] REG_ARRIVE_DISTANCE = 3'd2;
    localparam logic [2:0] REG_OBSTACLE_NEAR   = 3'd3;
    localparam logic [2:0] REG_OBSTACLE_FLOOR  = 3'd4;
    localparam logic [2:0] REG_CRUISE_SPEED    = 3'd5;

    typedef struct packed {
        logic start;
        logic vector_mode;
    } lts_cordic_cmd_t;

    // arctangent of 2^-i in units of 2^-20 rad
    function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        begin
            unique case (i)
                5'd0:    v = 24'sd823550;
                5'd1:    v = 24'sd486170;
                5'd2:    v = 24'sd256879;
                5'd3:    v = 24'sd130396;
                5'd4:    v = 24'sd65451;
                5'd5:    v = 24'sd32757;
                5'd6:    v = 24'sd16383;
                5'd7:    v = 24'sd8192;
                5'd8:    v = 24'sd4096;
                5'd9:    v = 24'sd2048;
                5'd10:   v = 24'sd1024;
                5'd11:   v = 24'sd512;
                5'd12:   v = 24'sd256;
                5'd13:   v = 24'sd128;
                5'd14:   v = 24'sd64;
                5'd15:   v = 24'sd32;
                5'd16:   v = 24'sd16;
                5'd17:   v = 24'sd8;
                5'd18:   v = 24'sd4;
                5'd19:   v = 24'sd2;
                5'd20:   v = 24'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

/* hw/rtl/lts_cordic.sv */
module lts_cordic
    import lts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lts_cordic_cmd_t      cmd,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic                 busy,
    output logic signed [CW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);

    logic                 run_reg;
    logic                 mode_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [CW-1:0] px, py, sx, sy;
    logic signed [ZW-1:0] pz, ang;

    // quadrant pre-rotation
    always_comb
    begin
        px = x_in;
        py = y_in;
        pz = z_in;
        if (cmd.vector_mode)
        begin
            pz = '0;
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    px = y_in;
                    py = -x_in;
                    pz = ANG_PI_HALF;
                end
                else
                begin
                    px = -y_in;
                    py = x_in;
                    pz = -ANG_PI_HALF;
                end
            end
        end
        else if (z_in > ANG_PI_HALF)
        begin
            px = -y_in;
            py = x_in;
            pz = z_in - ANG_PI_HALF;
        end
        else if (z_in < -ANG_PI_HALF)
        begin
            px = y_in;
            py = -x_in;
            pz = z_in + ANG_PI_HALF;
        end
    end

    always_comb
    begin
        sx  = x_reg >>> cnt_reg;
        sy  = y_reg >>> cnt_reg;
        ang = atan_val(5'(cnt_reg));
        if (mode_reg ? (y_reg > 0) : (z_reg < 0))
        begin
            x_next = x_reg + sy;
            y_next = y_reg - sx;
            z_next = mode_reg ? z_reg + ang : z_reg + ang;
        end
        else
        begin
            x_next = x_reg - sy;
            y_next = y_reg + sx;
            z_next = z_reg - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (cmd.start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= '0;
        end
        else if (run_reg)
        begin
            if (cnt_reg == CNT_W'(NSTEPS - 1))
                run_reg <= 1'b0;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg <= cmd.vector_mode;
            x_reg    <= px;
            y_reg    <= py;
            z_reg    <= pz;
        end
        else if (run_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign busy  = run_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

/* hw/rtl/lts_mult.sv */
module lts_mult
    import lts_pkg::*;
(
    input  logic                 clk,
    input  logic signed [CW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [PW-1:0] p
);

    logic signed [PW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PW'(a) * PW'(b);
    end

    assign p = p_reg;

endmodule

/* hw/rtl/line_tracking_steering.sv */
// channel | handshake          | payload
// in      | in_valid, in_stall | kind, robot_x/y, robot_yaw, target_x/y, nearest_range
// out     | out_valid, out_stall | linear_speed, angular_rate, blocked, done_res, last
// cfg     | cfg_we             | cfg_index, cfg_data
//
// A start item waits for the iterative CORDIC, which it skips for a zero-length line.
// Before its first result, a tracking tick makes three passes through the one shared
// multiplier and, unless blocked, a CORDIC rotation and three more passes.
// in_stall stays high from acceptance until the last result is taken, or until an item with no result is done.
// A stalled result holds its register; reset clears tracking and the sequencer.
module line_tracking_steering
    import lts_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic signed [POSITION_BITS-1:0] robot_x,
    input  logic signed [POSITION_BITS-1:0] robot_y,
    input  logic signed [15:0]              robot_yaw,
    input  logic signed [POSITION_BITS-1:0] target_x,
    input  logic signed [POSITION_BITS-1:0] target_y,
    input  logic [15:0]                     nearest_range,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [15:0]                     linear_speed,
    output logic signed [14:0]              angular_rate,
    output logic                            blocked,
    output logic                            done_res,
    output logic                            last,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [15:0]                     cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_VGO   = 4'd1;
    localparam logic [3:0] S_VWAIT = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_TICK  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_RGO   = 4'd7;
    localparam logic [3:0] S_RWAIT = 4'd8;
    localparam logic [3:0] S_RATE  = 4'd9;
    localparam logic [3:0] S_OUT1  = 4'd10;
    localparam logic [3:0] S_OUT2  = 4'd11;

    localparam logic [2:0] OP_SQX = 3'd0;
    localparam logic [2:0] OP_SQY = 3'd1;
    localparam logic [2:0] OP_SQA = 3'd2;
    localparam logic [2:0] OP_CT  = 3'd3;
    localparam logic [2:0] OP_HE  = 3'd4;
    localparam logic [2:0] OP_OG  = 3'd5;

    logic [3:0]  state_reg;
    logic [2:0]  mop_reg;
    logic        tracking_reg;

    logic signed [12:0] heading_gain_reg, offset_gain_reg;
    logic [15:0] arrive_reg, near_reg, floor_reg, cruise_reg;

    logic signed [POSITION_BITS-1:0] rx_reg, ry_reg;
    logic signed [15:0] yaw_reg;
    logic [15:0] range_reg;
    logic signed [POSITION_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [15:0] angle_reg;
    logic signed [16:0] he_reg;

    logic [DW-1:0] dxa_reg, dya_reg;
    logic          small_reg, blk_reg, arrived_reg;
    logic signed [PW-1:0] sq_reg, acc_reg;
    logic signed [CW-1:0] ct_reg;

    logic [15:0]        spd_reg;
    logic signed [14:0] rate_reg;
    logic               blocked_reg, done_reg, last_reg;

    lts_cordic_cmd_t      cmd;
    logic signed [CW-1:0] cx, cy;
    logic signed [ZW-1:0] cz;
    logic                 c_busy;
    logic signed [CW-1:0] c_y;
    logic signed [ZW-1:0] c_z;

    logic signed [CW-1:0] ma;
    logic signed [BW-1:0] mb;
    logic signed [PW-1:0] prod;

    logic signed [DW-1:0] dx_t, dy_t;
    logic signed [DW-1:0] dxr_t, dyr_t;
    logic signed [ZW-1:0] zr;
    logic signed [16:0]   diff;
    logic signed [PW-1:0] rnd;
    logic                 accept_in, accept_out;

    assign accept_in  = in_valid && !in_stall;
    assign accept_out = out_valid && !out_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_OUT1) || (state_reg == S_OUT2);

    lts_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .x_in  (cx),
        .y_in  (cy),
        .z_in  (cz),
        .busy  (c_busy),
        .y_out (c_y),
        .z_out (c_z)
    );

    lts_mult u_mult (
        .clk (clk),
        .a   (ma),
        .b   (mb),
        .p   (prod)
    );

    always_comb
    begin
        dx_t  = DW'(ex_reg) - DW'(sx_reg);
        dy_t  = DW'(ey_reg) - DW'(sy_reg);
        dxr_t = DW'(ex_reg) - DW'(rx_reg);
        dyr_t = DW'(ey_reg) - DW'(ry_reg);
        cmd.start       = (state_reg == S_VGO && (dx_t != 0 || dy_t != 0))
                          || (state_reg == S_RGO);
        cmd.vector_mode = (state_reg == S_VGO);
        if (state_reg == S_VGO)
        begin
            cx = CW'(dx_t);
            cy = CW'(dy_t);
        end
        else
        begin
            cx = CW'(rx_reg) - CW'(sx_reg);
            cy = CW'(ry_reg) - CW'(sy_reg);
        end
        cz = -(ZW'(angle_reg) <<< 7);
        zr = c_z + ZW'(64);
        diff = 17'(yaw_reg) - 17'(angle_reg);
        rnd  = (acc_reg + PW'(128)) >>> 8;
    end

    always_comb
    begin
        unique case (mop_reg)
            OP_SQX:
            begin
                ma = CW'({1'b0, dxa_reg[15:0]});
                mb = BW'({1'b0, dxa_reg[15:0]});
            end
            OP_SQY:
            begin
                ma = CW'({1'b0, dya_reg[15:0]});
                mb = BW'({1'b0, dya_reg[15:0]});
            end
            OP_SQA:
            begin
                ma = CW'({1'b0, arrive_reg});
                mb = BW'({1'b0, arrive_reg});
            end
            OP_CT:
            begin
                ma = c_y;
                mb = INV_GAIN;
            end
            OP_HE:
            begin
                ma = CW'(he_reg);
                mb = BW'(heading_gain_reg);
            end
            default:
            begin
                ma = ct_reg;
                mb = BW'(offset_gain_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_gain_reg <= -13'sd512;
            offset_gain_reg  <= -13'sd1024;
            arrive_reg       <= 16'd512;
            near_reg         <= 16'd1536;
            floor_reg        <= 16'd10;
            cruise_reg       <= 16'd512;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADING_GAIN:    heading_gain_reg <= cfg_data[12:0];
                REG_OFFSET_GAIN:     offset_gain_reg  <= cfg_data[12:0];
                REG_ARRIVE_DISTANCE: arrive_reg       <= cfg_data;
                REG_OBSTACLE_NEAR:   near_reg         <= cfg_data;
                REG_OBSTACLE_FLOOR:  floor_reg        <= cfg_data;
                REG_CRUISE_SPEED:    cruise_reg       <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tracking_reg <= 1'b0;
            mop_reg      <= OP_SQX;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (accept_in)
                        state_reg <= kind ? S_TICK : S_VGO;
                S_VGO:
                    state_reg <= (dx_t != 0 || dy_t != 0) ? S_VWAIT : S_HEAD;
                S_VWAIT:
                    if (!c_busy)
                        state_reg <= S_HEAD;
                S_HEAD:
                begin
                    tracking_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                S_TICK:
                begin
                    mop_reg   <= OP_SQX;
                    state_reg <= tracking_reg ? S_MUL : S_IDLE;
                end
                S_MUL:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    unique case (mop_reg)
                        OP_SQX: begin mop_reg <= OP_SQY; state_reg <= S_MUL; end
                        OP_SQY: begin mop_reg <= OP_SQA; state_reg <= S_MUL; end
                        OP_SQA: state_reg <= blk_reg ? S_OUT1 : S_RGO;
                        OP_CT:  begin mop_reg <= OP_HE;  state_reg <= S_MUL; end
                        OP_HE:  begin mop_reg <= OP_OG;  state_reg <= S_MUL; end
                        default: state_reg <= S_RATE;
                    endcase
                end
                S_RGO:
                    state_reg <= S_RWAIT;
                S_RWAIT:
                    if (!c_busy)
                    begin
                        mop_reg   <= OP_CT;
                        state_reg <= S_MUL;
                    end
                S_RATE:
                    state_reg <= S_OUT1;
                S_OUT1:
                    if (accept_out)
                    begin
                        if (arrived_reg)
                        begin
                            tracking_reg <= 1'b0;
                            state_reg    <= S_OUT2;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                S_OUT2:
                    if (accept_out)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (accept_in)
                begin
                    rx_reg    <= robot_x;
                    ry_reg    <= robot_y;
                    yaw_reg   <= robot_yaw;
                    range_reg <= nearest_range;
                    if (!kind)
                    begin
                        sx_reg <= robot_x;
                        sy_reg <= robot_y;
                        ex_reg <= target_x;
                        ey_reg <= target_y;
                    end
                end
            S_VGO:
                angle_reg <= '0;
            S_VWAIT:
                if (!c_busy)
                    angle_reg <= 16'(zr >>> 7);
            S_HEAD:
                he_reg <= (diff < -Q13_PI) ? diff + Q13_TWO_PI : diff;
            S_TICK:
            begin
                dxa_reg   <= (dxr_t < 0) ? DW'(-dxr_t) : DW'(dxr_t);
                dya_reg   <= (dyr_t < 0) ? DW'(-dyr_t) : DW'(dyr_t);
                blk_reg   <= (range_reg > floor_reg) && (range_reg < near_reg);
                sq_reg    <= '0;
            end
            S_MUL:
                small_reg <= (dxa_reg <= DW'(arrive_reg)) && (dya_reg <= DW'(arrive_reg));
            S_ACC:
            begin
                unique case (mop_reg)
                    OP_SQX: sq_reg <= sq_reg + prod;
                    OP_SQY: sq_reg <= sq_reg + prod;
                    OP_SQA:
                    begin
                        arrived_reg <= small_reg && (sq_reg <= prod);
                        spd_reg     <= '0;
                        rate_reg    <= '0;
                        blocked_reg <= 1'b1;
                        done_reg    <= 1'b0;
                        last_reg    <= !(small_reg && (sq_reg <= prod));
                    end
                    OP_CT: ct_reg  <= CW'((prod + PW'(32768)) >>> 16);
                    OP_HE: acc_reg <= prod;
                    default: acc_reg <= acc_reg + (prod <<< 3);
                endcase
            end
            S_RATE:
            begin
                spd_reg     <= cruise_reg;
                blocked_reg <= 1'b0;
                done_reg    <= 1'b0;
                last_reg    <= !arrived_reg;
                if (rnd > RATE_MAX)
                    rate_reg <= 15'(RATE_MAX);
                else if (rnd < -RATE_MAX)
                    rate_reg <= 15'(-RATE_MAX);
                else
                    rate_reg <= 15'(rnd);
            end
            S_OUT1:
                if (accept_out)
                begin
                    spd_reg     <= '0;
                    rate_reg    <= '0;
                    blocked_reg <= 1'b0;
                    done_reg    <= 1'b1;
                    last_reg    <= 1'b1;
                end
            default:
                ;
        endcase
    end

    assign linear_speed = spd_reg;
    assign angular_rate = rate_reg;
    assign blocked      = blocked_reg;
    assign done_res     = done_reg;
    assign last         = last_reg;

endmodule

/* hw/rtl/lts_checker.sv */
module lts_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [15:0]                     linear_speed,
    input logic signed [14:0]              angular_rate,
    input logic                            blocked,
    input logic                            done_res,
    input logic                            last
);

    // a stalled result stays valid and holds its rate and last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angular_rate) && $stable(last))
        else $error("stalled result changed");

    // an accepted item keeps the input side busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> last && linear_speed == 16'd0 && angular_rate == 15'sd0
        && !blocked)
        else $error("bad stop command");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angular_rate <= 15'sd12868 && angular_rate >= -15'sd12868
        && (!blocked || linear_speed == 16'd0))
        else $error("steering rate out of range");

endmodule

bind line_tracking_steering lts_checker u_lts_checker (.*);

/* tb/sv/line_tracking_steering_tb.sv */
`timescale 1ns / 100ps

module line_tracking_steering_tb;
    import lts_pkg::*;

    typedef struct {
        logic                            kind;
        logic signed [POSITION_BITS-1:0] rx;
        logic signed [POSITION_BITS-1:0] ry;
        logic signed [15:0]              yaw;
        logic signed [POSITION_BITS-1:0] tx;
        logic signed [POSITION_BITS-1:0] ty;
        logic [15:0]                     rng;
    } lts_item_t;

    typedef struct {
        logic [15:0]        speed;
        logic signed [14:0] rate;
        logic               blk;
        logic               dn;
        logic               lst;
    } lts_cmd_t;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic                            kind;
    logic signed [POSITION_BITS-1:0] robot_x;
    logic signed [POSITION_BITS-1:0] robot_y;
    logic signed [15:0]              robot_yaw;
    logic signed [POSITION_BITS-1:0] target_x;
    logic signed [POSITION_BITS-1:0] target_y;
    logic [15:0]                     nearest_range;
    logic                            out_valid;
    logic                            out_stall;
    logic [15:0]                     linear_speed;
    logic signed [14:0]              angular_rate;
    logic                            blocked;
    logic                            done_res;
    logic                            last;
    logic                            cfg_we;
    logic [2:0]                      cfg_index;
    logic [15:0]                     cfg_data;

    line_tracking_steering i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .robot_x       (robot_x),
        .robot_y       (robot_y),
        .robot_yaw     (robot_yaw),
        .target_x      (target_x),
        .target_y      (target_y),
        .nearest_range (nearest_range),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .linear_speed  (linear_speed),
        .angular_rate  (angular_rate),
        .blocked       (blocked),
        .done_res      (done_res),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // steering state and register copies
    longint    hg, og, arrive_d, near_d, floor_d, cruise;
    bit        tracking;
    longint    ls_x, ls_y, le_x, le_y;
    longint    line_ang, head_err;
    longint    atan_lut [24];

    lts_item_t pending [$];
    lts_cmd_t  cmd_q [$];
    int        idle_pct;
    bit        in_took;
    int        errors;
    int        quiet_cycles;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint steer_atan2(longint y, longint x);
        longint z;
        longint t;
        longint nx;
        longint ny;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 1647099;
            end
            else
            begin
                t = x; x = -y; y = t; z = -1647099;
            end
        end
        for (int i = 0; i < NSTEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_lut[i];
            end
            else
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_lut[i];
            end
            x = nx;
            y = ny;
        end
        return (z + 64) >>> 7;
    endfunction

    function automatic longint steer_offset(longint x, longint y, longint ang);
        longint z;
        longint t;
        longint nx;
        longint ny;
        z = -ang * 128;
        if (z > 1647099)
        begin
            t = x; x = -y; y = t; z -= 1647099;
        end
        else if (z < -1647099)
        begin
            t = x; x = y; y = -t; z += 1647099;
        end
        for (int i = 0; i < NSTEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_lut[i];
            end
            else
            begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_lut[i];
            end
            x = nx;
            y = ny;
        end
        return (y * 39797 + 32768) >>> 16;
    endfunction

    task automatic steer_predict(lts_item_t it);
        longint   ex;
        longint   ey;
        longint   ct;
        longint   rate;
        bit       arrived;
        lts_cmd_t c;
        if (it.kind == KIND_START)
        begin
            ls_x = it.rx;
            ls_y = it.ry;
            le_x = it.tx;
            le_y = it.ty;
            line_ang = steer_atan2(le_y - ls_y, le_x - ls_x);
            head_err = longint'(it.yaw) - line_ang;
            if (head_err < -25736)
                head_err += 51472;
            tracking = 1'b1;
            return;
        end
        if (!tracking)
            return;
        ex = le_x - it.rx;
        ey = le_y - it.ry;
        if (ex < 0) ex = -ex;
        if (ey < 0) ey = -ey;
        arrived = (ex <= arrive_d && ey <= arrive_d && ex * ex + ey * ey <= arrive_d * arrive_d);
        if (it.rng > floor_d && it.rng < near_d)
        begin
            c.speed = '0;
            c.rate  = '0;
            c.blk   = 1'b1;
        end
        else
        begin
            ct = steer_offset(it.rx - ls_x, it.ry - ls_y, line_ang);
            rate = (hg * head_err + og * ct * 8 + 128) >>> 8;
            if (rate > 12868) rate = 12868;
            if (rate < -12868) rate = -12868;
            c.speed = cruise[15:0];
            c.rate  = rate[14:0];
            c.blk   = 1'b0;
        end
        c.dn  = 1'b0;
        c.lst = !arrived;
        cmd_q.insert(cmd_q.size(), c);
        if (arrived)
        begin
            c.speed = '0;
            c.rate  = '0;
            c.blk   = 1'b0;
            c.dn    = 1'b1;
            c.lst   = 1'b1;
            cmd_q.insert(cmd_q.size(), c);
            tracking = 1'b0;
        end
    endtask

    // acceptance on both channels, checking and watchdog
    always @(posedge clk)
    begin
        lts_item_t it;
        lts_cmd_t  e;
        in_took = rst_n && in_valid && !in_stall;
        if (in_took)
        begin
            it.kind = kind; it.rx = robot_x; it.ry = robot_y; it.yaw = robot_yaw;
            it.tx = target_x; it.ty = target_y; it.rng = nearest_range;
            steer_predict(it);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (cmd_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result speed %0d rate %0d blk %0b done %0b last %0b",
                         $time, linear_speed, angular_rate, blocked, done_res, last);
            end
            else
            begin
                e = cmd_q.pop_front();
                if (linear_speed !== e.speed || angular_rate !== e.rate || blocked !== e.blk
                    || done_res !== e.dn || last !== e.lst)
                begin
                    errors++;
                    $display("%0t: expected speed %0d rate %0d blk %0b done %0b last %0b",
                             $time, e.speed, e.rate, e.blk, e.dn, e.lst);
                    $display("%0t: actual   speed %0d rate %0d blk %0b done %0b last %0b",
                             $time, linear_speed, angular_rate, blocked, done_res, last);
                end
            end
        end
        if (in_took || (out_valid && !out_stall) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("line_tracking_steering regression: fail");
            $finish;
        end
    end

    // input driver: hold an item until it is taken
    always @(negedge clk)
    begin
        lts_item_t it;
        if (rst_n && (!in_valid || in_took))
        begin
            if (pending.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                it = pending.pop_front();
                in_valid      <= 1'b1;
                kind          <= it.kind;
                robot_x       <= it.rx;
                robot_y       <= it.ry;
                robot_yaw     <= it.yaw;
                target_x      <= it.tx;
                target_y      <= it.ty;
                nearest_range <= it.rng;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < idle_pct);

    function automatic logic [23:0] rnd_pos();
        return 24'($urandom());
    endfunction

    function automatic logic [23:0] near_pos(logic [23:0] base, int span);
        int off;
        off = $urandom_range(0, 2 * span) - span;
        return 24'(base + off);
    endfunction

    function automatic logic [15:0] rnd_yaw();
        return 16'($urandom_range(0, 51472) - 25736);
    endfunction

    function automatic logic [15:0] rnd_range();
        case ($urandom_range(0, 5))
            0: return floor_d[15:0];
            1: return near_d[15:0];
            2, 3: return 16'($urandom_range(32'(floor_d), 32'(near_d)));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic add_item(logic k, logic [23:0] rx, logic [23:0] ry, logic [15:0] yaw,
                            logic [23:0] tx, logic [23:0] ty, logic [15:0] rng);
        lts_item_t it;
        it.kind = k; it.rx = rx; it.ry = ry; it.yaw = yaw;
        it.tx = tx; it.ty = ty; it.rng = rng;
        pending.insert(pending.size(), it);
    endtask

    // one line: a start, ticks around its start, mostly ending near the target
    task automatic add_track(int n_ticks);
        logic [23:0] sx;
        logic [23:0] sy;
        logic [23:0] tx;
        logic [23:0] ty;
        int          span;
        int          ad;
        sx = rnd_pos();
        sy = rnd_pos();
        span = (1 << $urandom_range(4, 22));
        tx = ($urandom_range(0, 9) == 0) ? sx : near_pos(sx, span);
        ty = ($urandom_range(0, 9) == 0) ? sy : near_pos(sy, span);
        if ($urandom_range(0, 7) == 0)
        begin
            tx = rnd_pos();
            ty = rnd_pos();
        end
        add_item(KIND_START, sx, sy, rnd_yaw(), tx, ty, 16'($urandom()));
        for (int i = 0; i < n_ticks; i++)
            add_item(KIND_TICK, near_pos(sx, span), near_pos(sy, span), 16'($urandom()),
                     rnd_pos(), rnd_pos(), rnd_range());
        if ($urandom_range(0, 3) != 0)
        begin
            ad = (arrive_d > 40000) ? 40000 : int'(arrive_d);
            add_item(KIND_TICK, near_pos(tx, ad / 2), near_pos(ty, ad / 2), 16'($urandom()),
                     rnd_pos(), rnd_pos(), rnd_range());
        end
        // stray tick while idle or noise
        if ($urandom_range(0, 4) == 0)
            add_item(KIND_TICK, rnd_pos(), rnd_pos(), 16'($urandom()), rnd_pos(), rnd_pos(),
                     16'($urandom()));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_HEADING_GAIN:    hg = longint'($signed(val[12:0]));
            REG_OFFSET_GAIN:     og = longint'($signed(val[12:0]));
            REG_ARRIVE_DISTANCE: arrive_d = val;
            REG_OBSTACLE_NEAR:   near_d = val;
            REG_OBSTACLE_FLOOR:  floor_d = val;
            REG_CRUISE_SPEED:    cruise = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending.size() != 0 || in_valid || cmd_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        atan_lut = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                     4096, 2048, 1024, 512, 256, 128, 64, 32,
                     16, 8, 4, 2, 1, 0, 0, 0};
        hg = -512; og = -1024; arrive_d = 512; near_d = 1536; floor_d = 10; cruise = 512;
        tracking = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        in_took = 1'b0;
        idle_pct = 17;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        kind = 1'b0;
        robot_x = '0; robot_y = '0; robot_yaw = '0;
        target_x = '0; target_y = '0; nearest_range = '0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed: tick with no line, extremes, zero-length line, blocking, arrival
        add_item(KIND_TICK, 24'h000000, 24'h000000, 16'sd0, 24'h0, 24'h0, 16'd0);
        add_item(KIND_START, 24'h800000, 24'h800000, -16'sd25736, 24'h7FFFFF, 24'h7FFFFF, 16'd0);
        add_item(KIND_TICK, 24'h7FFFFF, 24'h800000, 16'sd0, 24'h0, 24'h0, 16'hFFFF);
        add_item(KIND_TICK, 24'h000000, 24'h7FFFFF, 16'sd0, 24'h0, 24'h0, 16'd11);
        add_item(KIND_TICK, 24'h000000, 24'h000000, 16'sd0, 24'h0, 24'h0, 16'd10);
        add_item(KIND_TICK, 24'h000000, 24'h000000, 16'sd0, 24'h0, 24'h0, 16'd1535);
        add_item(KIND_TICK, 24'h000000, 24'h000000, 16'sd0, 24'h0, 24'h0, 16'd1536);
        add_item(KIND_START, 24'h7FFFFF, 24'h7FFFFF, 16'sd25736, 24'h800000, 24'h800000, 16'd0);
        add_item(KIND_TICK, 24'h800000, 24'h800000, 16'sd0, 24'h0, 24'h0, 16'd0);
        add_item(KIND_START, 24'h001000, 24'h002000, 16'sd25736, 24'h001000, 24'h002000, 16'd0);
        add_item(KIND_TICK, 24'h001200, 24'h002000, 16'sd0, 24'h0, 24'h0, 16'd100);
        add_item(KIND_START, 24'h000000, 24'h000000, -16'sd25000, 24'hFFF000, 24'h000400, 16'd0);
        add_item(KIND_TICK, 24'h000000, 24'h000300, 16'sd0, 24'h0, 24'h0, 16'd5000);
        add_item(KIND_START, 24'h000000, 24'h000000, 16'sd20000, 24'hFFF000, 24'hFFF000, 16'd0);
        add_item(KIND_TICK, 24'hFFF000, 24'hFFF100, 16'sd0, 24'h0, 24'h0, 16'd5000);
        add_item(KIND_TICK, 24'hFFF000, 24'hFFF000, 16'sd0, 24'h0, 24'h0, 16'd0);
        add_item(KIND_TICK, 24'hFFF000, 24'hFFF000, 16'sd0, 24'h0, 24'h0, 16'd0);
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: ;
                1:
                begin
                    write_reg(REG_HEADING_GAIN, 16'h0FFF);
                    write_reg(REG_OFFSET_GAIN, 16'h0FFF);
                    write_reg(REG_ARRIVE_DISTANCE, 16'd0);
                    write_reg(REG_OBSTACLE_NEAR, 16'd0);
                    write_reg(REG_OBSTACLE_FLOOR, 16'd0);
                    write_reg(REG_CRUISE_SPEED, 16'hFFFF);
                end
                2:
                begin
                    write_reg(REG_HEADING_GAIN, 16'h1000);
                    write_reg(REG_OFFSET_GAIN, 16'h1000);
                    write_reg(REG_ARRIVE_DISTANCE, 16'hFFFF);
                    write_reg(REG_OBSTACLE_NEAR, 16'hFFFF);
                    write_reg(REG_OBSTACLE_FLOOR, 16'hFFFF);
                    write_reg(REG_CRUISE_SPEED, 16'd0);
                end
                3:
                begin
                    write_reg(REG_OBSTACLE_FLOOR, 16'd0);
                    write_reg(REG_ARRIVE_DISTANCE, 16'd2000);
                    idle_pct = 0;
                end
                default:
                begin
                    idle_pct = 17;
                    write_reg(REG_HEADING_GAIN, 16'($urandom()));
                    write_reg(REG_OFFSET_GAIN, 16'($urandom()));
                    write_reg(REG_ARRIVE_DISTANCE, 16'($urandom_range(0, 4000)));
                    write_reg(REG_OBSTACLE_FLOOR, 16'($urandom_range(0, 2000)));
                    write_reg(REG_OBSTACLE_NEAR, 16'($urandom_range(1000, 8000)));
                    write_reg(REG_CRUISE_SPEED, 16'($urandom()));
                end
            endcase
            while (pending.size() < 130)
                add_track($urandom_range(0, 6));
            drain();
        end

        if (errors == 0)
            $display("line_tracking_steering regression: pass");
        else
            $display("line_tracking_steering regression: fail");
        $finish;
    end

endmodule
